@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros used by the checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// Checked on every edge, reset included
`define ASSERT_CLK_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`endif

@@ rtl/core/bwrs_pkg.sv @@
// ----------------------------------------------------------------------------
// bwrs_pkg
// Types and constants of the burn-wire retry sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bwrs_pkg;

    // sequence phases
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_BURN  = 2'd1;
    localparam logic [1:0] PH_PAUSE = 2'd2;

    // configuration register indexes
    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_FIRST_WINDOW = 3'd0;
    localparam t_cfg_idx CFG_RETRY_WINDOW = 3'd1;
    localparam t_cfg_idx CFG_MAX_ATTEMPTS = 3'd2;
    localparam t_cfg_idx CFG_PAUSE_TICKS  = 3'd3;
    localparam t_cfg_idx CFG_DUTY_START   = 3'd4;
    localparam t_cfg_idx CFG_DUTY_STEP    = 3'd5;

    localparam int CFG_DATA_W = 16;

    // register reset values
    localparam logic [7:0]  RST_FIRST_WINDOW = 8'd4;
    localparam logic [7:0]  RST_RETRY_WINDOW = 8'd5;
    localparam logic [3:0]  RST_MAX_ATTEMPTS = 4'd5;
    localparam logic [15:0] RST_PAUSE_TICKS  = 16'd200;
    localparam logic [6:0]  RST_DUTY_START   = 7'd20;
    localparam logic [6:0]  RST_DUTY_STEP    = 7'd5;

    localparam logic [6:0]  DUTY_MAX = 7'd100;
    localparam logic [15:0] TICK_MAX = 16'hFFFF;

    typedef struct packed {
        logic [7:0]  first_window_s;
        logic [7:0]  retry_window_s;
        logic [3:0]  max_attempts;
        logic [15:0] pause_ticks;
        logic [6:0]  duty_start;
        logic [6:0]  duty_step;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  phase;
        logic [3:0]  attempt_count;
        logic [15:0] tick_count;
        logic [15:0] window_ticks;
        logic [6:0]  duty_now;
    } t_state;

    // first field in the highest bit
    typedef struct packed {
        logic       success;
        logic       done_res;
        logic       watchdog_kick;
        logic [6:0] burn_duty;
        logic       burn_active;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/core/burn_wire_retry_sequencer.sv @@
// The result of an item is registered and is on the output in the cycle after it is accepted.
// Throughput: one item per cycle while the output is not stalled; the output register lets
// the next item in while the current result is being taken.
// Reset (synchronous, active low): sequence idle, counters cleared, output empty,
// configuration registers back to their defaults.
// ----------------------------------------------------------------------------
// burn_wire_retry_sequencer
// Burn-wire deployment sequencer with timed windows, pauses and duty retries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module burn_wire_retry_sequencer #(
    parameter int TICKS_PER_SECOND = 100
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    // configuration
    input  wire        i_cfg_we,
    input  wire [2:0]  i_cfg_idx,
    input  wire [bwrs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input items
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire [7:0]  s_axis_tdata,   // [0] retry_flag, [1] burned_seen, rest zero
    input  wire        s_axis_tuser,   // [0] kind
    // result items
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [15:0] m_axis_tdata   // [0] burn_active, [7:1] burn_duty,
                                       // [8] watchdog_kick, [9] done_res,
                                       // [10] success, rest zero
);

    localparam int SEC_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;

    bwrs_pkg::t_cfg    r_cfg;
    bwrs_pkg::t_state  r_state;
    bwrs_pkg::t_state  n_state;
    logic [SEC_W-1:0]  r_sec_cnt;
    logic [SEC_W-1:0]  n_sec_cnt;
    bwrs_pkg::t_result r_result;
    bwrs_pkg::t_result n_result;
    logic              r_out_valid;
    logic              in_fire;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_result};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_window_s <= bwrs_pkg::RST_FIRST_WINDOW;
            r_cfg.retry_window_s <= bwrs_pkg::RST_RETRY_WINDOW;
            r_cfg.max_attempts   <= bwrs_pkg::RST_MAX_ATTEMPTS;
            r_cfg.pause_ticks    <= bwrs_pkg::RST_PAUSE_TICKS;
            r_cfg.duty_start     <= bwrs_pkg::RST_DUTY_START;
            r_cfg.duty_step      <= bwrs_pkg::RST_DUTY_STEP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bwrs_pkg::CFG_FIRST_WINDOW: r_cfg.first_window_s <= i_cfg_data[7:0];
                bwrs_pkg::CFG_RETRY_WINDOW: r_cfg.retry_window_s <= i_cfg_data[7:0];
                bwrs_pkg::CFG_MAX_ATTEMPTS: r_cfg.max_attempts   <= i_cfg_data[3:0];
                bwrs_pkg::CFG_PAUSE_TICKS:  r_cfg.pause_ticks    <= i_cfg_data;
                bwrs_pkg::CFG_DUTY_START:   r_cfg.duty_start     <= i_cfg_data[6:0];
                bwrs_pkg::CFG_DUTY_STEP:    r_cfg.duty_step      <= i_cfg_data[6:0];
                default: begin
                    // unmapped index: write dropped
                end
            endcase
        end
    end

    bwrs_step #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND),
        .SEC_W            (SEC_W)
    ) u_step (
        .i_state       (r_state),
        .i_sec_cnt     (r_sec_cnt),
        .i_cfg         (r_cfg),
        .i_kind        (s_axis_tuser),
        .i_retry_flag  (s_axis_tdata[0]),
        .i_burned_seen (s_axis_tdata[1]),
        .o_state       (n_state),
        .o_sec_cnt     (n_sec_cnt),
        .o_result      (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase         <= bwrs_pkg::PH_IDLE;
            r_state.attempt_count <= 4'd0;
            r_state.tick_count    <= 16'd0;
            r_state.window_ticks  <= 16'd0;
            r_state.duty_now      <= 7'd0;
            r_sec_cnt             <= '0;
            r_out_valid           <= 1'b0;
        end else if (in_fire) begin
            r_state     <= n_state;
            r_sec_cnt   <= n_sec_cnt;
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_result <= n_result;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/bwrs_step.sv @@
// ----------------------------------------------------------------------------
// bwrs_step
// Next-state and result logic for one item of the burn sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bwrs_step #(
    parameter int TICKS_PER_SECOND = 100,
    parameter int SEC_W            = 7
) (
    input  var bwrs_pkg::t_state  i_state,
    input  wire [SEC_W-1:0]       i_sec_cnt,
    input  var bwrs_pkg::t_cfg    i_cfg,
    input  wire                   i_kind,
    input  wire                   i_retry_flag,
    input  wire                   i_burned_seen,
    output bwrs_pkg::t_state      o_state,
    output logic [SEC_W-1:0]      o_sec_cnt,
    output bwrs_pkg::t_result     o_result
);

    localparam int TPS_W  = $clog2(TICKS_PER_SECOND + 1);
    localparam int PROD_W = (8 + TPS_W > 16) ? 8 + TPS_W : 17;
    localparam logic [SEC_W-1:0] SEC_LAST = SEC_W'(TICKS_PER_SECOND - 1);

    logic [7:0]        secs_sel;
    logic [7:0]        secs_eff;
    logic [PROD_W-1:0] win_prod;
    logic [15:0]       win_start;
    logic [6:0]        duty_first;
    logic [3:0]        limit;
    logic [3:0]        att_inc;
    logic              last_attempt;
    logic [7:0]        duty_sum;
    logic [6:0]        duty_raised;
    logic [15:0]       tick_inc;
    logic              kick;
    logic              done;
    logic              ok;
    logic              active;

    // window latched at start, saturated to 16 bits
    always_comb begin
        secs_sel  = i_retry_flag ? i_cfg.retry_window_s : i_cfg.first_window_s;
        secs_eff  = (secs_sel == 8'd0) ? 8'd1 : secs_sel;
        win_prod  = PROD_W'(secs_eff) * PROD_W'(TICKS_PER_SECOND);
        win_start = (win_prod > PROD_W'(bwrs_pkg::TICK_MAX)) ? bwrs_pkg::TICK_MAX
                                                            : win_prod[15:0];
        duty_first = (i_cfg.duty_start > bwrs_pkg::DUTY_MAX) ? bwrs_pkg::DUTY_MAX
                                                             : i_cfg.duty_start;
    end

    always_comb begin
        limit        = (i_cfg.max_attempts == 4'd0) ? 4'd1 : i_cfg.max_attempts;
        att_inc      = i_state.attempt_count + 4'd1;
        last_attempt = (att_inc >= limit) || (att_inc == 4'd0);
        duty_sum     = {1'b0, i_state.duty_now} + {1'b0, i_cfg.duty_step};
        duty_raised  = (duty_sum > {1'b0, bwrs_pkg::DUTY_MAX}) ? bwrs_pkg::DUTY_MAX
                                                               : duty_sum[6:0];
        tick_inc     = i_state.tick_count + 16'd1;
    end

    always_comb begin
        o_state   = i_state;
        o_sec_cnt = i_sec_cnt;
        kick      = 1'b0;
        done      = 1'b0;
        ok        = 1'b0;

        if (!i_kind) begin
            o_state.window_ticks  = win_start;
            o_state.duty_now      = duty_first;
            o_state.attempt_count = 4'd0;
            o_state.tick_count    = 16'd0;
            o_state.phase         = bwrs_pkg::PH_BURN;
            o_sec_cnt             = '0;
        end else begin
            unique case (i_state.phase)
                bwrs_pkg::PH_BURN: begin
                    if (i_burned_seen) begin
                        o_state.phase      = bwrs_pkg::PH_IDLE;
                        o_state.tick_count = 16'd0;
                        done               = 1'b1;
                        ok                 = 1'b1;
                    end else begin
                        // sub-second counter tracks tick_count mod TICKS_PER_SECOND
                        kick               = (i_sec_cnt == '0);
                        o_state.tick_count = tick_inc;
                        o_sec_cnt          = (i_sec_cnt == SEC_LAST) ? '0 : i_sec_cnt + 1'b1;
                        if (tick_inc >= i_state.window_ticks) begin
                            o_state.tick_count = 16'd0;
                            o_sec_cnt          = '0;
                            o_state.phase      = bwrs_pkg::PH_PAUSE;
                            // zero pause: end of pause on this same tick
                            if (i_cfg.pause_ticks == 16'd0) begin
                                o_state.attempt_count = att_inc;
                                if (last_attempt) begin
                                    o_state.phase = bwrs_pkg::PH_IDLE;
                                    done          = 1'b1;
                                end else begin
                                    o_state.duty_now = duty_raised;
                                    o_state.phase    = bwrs_pkg::PH_BURN;
                                end
                            end
                        end
                    end
                end
                bwrs_pkg::PH_PAUSE: begin
                    o_state.tick_count = tick_inc;
                    if (tick_inc >= i_cfg.pause_ticks) begin
                        o_state.attempt_count = att_inc;
                        o_state.tick_count    = 16'd0;
                        o_sec_cnt             = '0;
                        if (last_attempt) begin
                            o_state.phase = bwrs_pkg::PH_IDLE;
                            done          = 1'b1;
                        end else begin
                            o_state.duty_now = duty_raised;
                            o_state.phase    = bwrs_pkg::PH_BURN;
                        end
                    end
                end
                default: begin
                    // idle: ticks change nothing
                end
            endcase
        end

        active                 = (o_state.phase == bwrs_pkg::PH_BURN);
        o_result.burn_active   = active;
        o_result.burn_duty     = active ? o_state.duty_now : 7'd0;
        o_result.watchdog_kick = kick;
        o_result.done_res      = done;
        o_result.success       = ok;
    end

endmodule

`default_nettype wire

@@ rtl/core/bwrs_checker.sv @@
// ----------------------------------------------------------------------------
// bwrs_checker
// Port-level checks of the burn-wire retry sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bwrs_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [15:0] m_axis_tdata
);

    wire       stall      = m_axis_tvalid && !m_axis_tready;
    wire       res_active = m_axis_tdata[0];
    wire [6:0] res_duty   = m_axis_tdata[7:1];
    wire       res_done   = m_axis_tdata[9];
    wire       res_end    = m_axis_tdata[9] || m_axis_tdata[10];

    // output register empties on reset
    `ASSERT_CLK_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !m_axis_tvalid)

    // a held result keeps its value
    `ASSERT_CLK(a_hold, i_clk, i_rst_n, stall |=> m_axis_tvalid && $stable(m_axis_tdata))

    // a full, stalled output register blocks the input
    `ASSERT_CLK(a_backpressure, i_clk, i_rst_n, stall |-> !s_axis_tready)

    // duty reads zero while the wire is off
    `ASSERT_CLK(a_duty_off, i_clk, i_rst_n, m_axis_tvalid && !res_active |-> res_duty == 7'd0)

    // a finished sequence leaves the wire off; success only with done
    `ASSERT_CLK(a_done_off, i_clk, i_rst_n, m_axis_tvalid && res_end |-> res_done && !res_active)

endmodule

bind burn_wire_retry_sequencer bwrs_checker u_bwrs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Burn-wire retry sequencer testbench
// Sends start and tick items through the input stream, predicts every
// result with a cycle-free model of the sequencer, and checks each result
// field. Runs several register settings, including the out-of-range and
// extreme values, with random stalls on both streams and one long stall at
// the output.
// ----------------------------------------------------------------------------

module testbench;

    localparam int TICKS_PER_SEC = 100;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD = 150;

    // item kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    typedef struct packed {
        logic kind;
        logic retry;
        logic seen;
    } t_item;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    bwrs_pkg::t_cfg_idx i_cfg_idx = bwrs_pkg::CFG_FIRST_WINDOW;
    logic [15:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [0] retry_flag, [1] burned_seen, rest zero
    logic        s_axis_tuser = 1'b0;  // [0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // [0] burn_active, [7:1] burn_duty,
                                       // [8] watchdog_kick, [9] done_res,
                                       // [10] success, rest zero

    burn_wire_retry_sequencer #(
        .TICKS_PER_SECOND(TICKS_PER_SEC)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // register copies
    logic [7:0]  cfg_first_s;
    logic [7:0]  cfg_retry_s;
    logic [3:0]  cfg_attempts;
    logic [15:0] cfg_pause;
    logic [6:0]  cfg_duty_start;
    logic [6:0]  cfg_duty_step;

    // sequencer state
    logic [1:0]  seq_phase;
    logic [3:0]  seq_attempt;
    logic [15:0] seq_ticks;
    logic [15:0] seq_window;
    logic [6:0]  seq_duty;

    t_item             pending_items[$];
    bwrs_pkg::t_result expected_results[$];
    t_item             next_item;
    bwrs_pkg::t_result want;
    bwrs_pkg::t_result got;

    int  send_gap = 0;
    int  hold_left = 0;
    int  results_seen = 0;
    int  fail_count = 0;
    int  quiet_cycles = 0;
    bit  pressure_done = 1'b0;
    bit  calm = 1'b0;

    // Ends a pause: next attempt with raised duty, or failure. 1 on failure.
    function automatic logic close_pause();
        logic [3:0] limit;
        logic [7:0] raised;
        limit = (cfg_attempts == 4'd0) ? 4'd1 : cfg_attempts;
        seq_attempt = seq_attempt + 4'd1;
        seq_ticks = '0;
        if (seq_attempt >= limit || seq_attempt == 4'd0) begin
            seq_phase = bwrs_pkg::PH_IDLE;
            return 1'b1;
        end
        raised = seq_duty + cfg_duty_step;
        seq_duty = (raised > bwrs_pkg::DUTY_MAX) ? bwrs_pkg::DUTY_MAX : raised[6:0];
        seq_phase = bwrs_pkg::PH_BURN;
        return 1'b0;
    endfunction

    function automatic bwrs_pkg::t_result advance_sequencer(logic kind, logic retry,
                                                            logic seen);
        bwrs_pkg::t_result r;
        logic [7:0] secs;
        int span;
        r = '0;
        if (kind == KIND_START) begin
            secs = retry ? cfg_retry_s : cfg_first_s;
            if (secs == 8'd0)
                secs = 8'd1;
            span = secs * TICKS_PER_SEC;
            seq_window = (span > bwrs_pkg::TICK_MAX) ? bwrs_pkg::TICK_MAX : span[15:0];
            seq_duty = (cfg_duty_start > bwrs_pkg::DUTY_MAX) ? bwrs_pkg::DUTY_MAX
                                                             : cfg_duty_start;
            seq_attempt = '0;
            seq_ticks = '0;
            seq_phase = bwrs_pkg::PH_BURN;
        end else if (seq_phase == bwrs_pkg::PH_BURN) begin
            if (seen) begin
                seq_phase = bwrs_pkg::PH_IDLE;
                seq_ticks = '0;
                r.done_res = 1'b1;
                r.success = 1'b1;
            end else begin
                // kick on the first tick of each second of burning
                if (seq_ticks % TICKS_PER_SEC == 0)
                    r.watchdog_kick = 1'b1;
                seq_ticks = seq_ticks + 16'd1;
                if (seq_ticks >= seq_window) begin
                    seq_ticks = '0;
                    seq_phase = bwrs_pkg::PH_PAUSE;
                    if (cfg_pause == 16'd0) begin
                        if (close_pause())
                            r.done_res = 1'b1;
                    end
                end
            end
        end else if (seq_phase == bwrs_pkg::PH_PAUSE) begin
            seq_ticks = seq_ticks + 16'd1;
            if (seq_ticks >= cfg_pause) begin
                if (close_pause())
                    r.done_res = 1'b1;
            end
        end
        r.burn_active = (seq_phase == bwrs_pkg::PH_BURN);
        r.burn_duty = (seq_phase == bwrs_pkg::PH_BURN) ? seq_duty : 7'd0;
        return r;
    endfunction

    task automatic push_item(logic kind, logic retry, logic seen);
        t_item it;
        it.kind = kind;
        it.retry = retry;
        it.seen = seen;
        pending_items.push_back(it);
    endtask

    task automatic write_register(bwrs_pkg::t_cfg_idx idx, logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        case (idx)
            bwrs_pkg::CFG_FIRST_WINDOW: cfg_first_s = value[7:0];
            bwrs_pkg::CFG_RETRY_WINDOW: cfg_retry_s = value[7:0];
            bwrs_pkg::CFG_MAX_ATTEMPTS: cfg_attempts = value[3:0];
            bwrs_pkg::CFG_PAUSE_TICKS:  cfg_pause = value;
            bwrs_pkg::CFG_DUTY_START:   cfg_duty_start = value[6:0];
            bwrs_pkg::CFG_DUTY_STEP:    cfg_duty_step = value[6:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(logic [7:0] first_s, logic [7:0] retry_s,
                                 logic [3:0] attempts, logic [15:0] pause,
                                 logic [6:0] duty_start, logic [6:0] duty_step);
        write_register(bwrs_pkg::CFG_FIRST_WINDOW, {8'd0, first_s});
        write_register(bwrs_pkg::CFG_RETRY_WINDOW, {8'd0, retry_s});
        write_register(bwrs_pkg::CFG_MAX_ATTEMPTS, {12'd0, attempts});
        write_register(bwrs_pkg::CFG_PAUSE_TICKS, pause);
        write_register(bwrs_pkg::CFG_DUTY_START, {9'd0, duty_start});
        write_register(bwrs_pkg::CFG_DUTY_STEP, {9'd0, duty_step});
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Start items each followed by a run of ticks; confirmations are
    // frequent in some runs and rare in others so windows and pauses expire.
    task automatic queue_sequences(int n_items, int max_ticks);
        int left;
        int n_ticks;
        int seen_odds;
        left = n_items;
        while (left > 0) begin
            if ($urandom_range(0, 9) == 0) begin
                // stray tick ahead of the start
                push_item(KIND_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                left--;
            end
            push_item(KIND_START, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            left--;
            n_ticks = $urandom_range(1, max_ticks);
            if (n_ticks > left)
                n_ticks = left;
            seen_odds = ($urandom_range(0, 3) == 0) ? 15 : 1500;
            repeat (n_ticks)
                push_item(KIND_TICK, 1'($urandom_range(0, 1)),
                          $urandom_range(0, seen_odds - 1) == 0);
            left -= n_ticks;
        end
    endtask

    // wait until every item is sent and every result is back
    task automatic drain();
        while (pending_items.size() != 0 || expected_results.size() != 0
               || s_axis_tvalid || m_axis_tvalid)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // input driver and prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(
                    advance_sequencer(s_axis_tuser, s_axis_tdata[0], s_axis_tdata[1]));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_items.size() != 0 && !calm
                             && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(0, 4);
                    s_axis_tvalid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    next_item = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= next_item.kind;
                    s_axis_tdata <= {6'd0, next_item.seen, next_item.retry};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and output stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("result item with no expectation: %h", m_axis_tdata);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    got = bwrs_pkg::t_result'(m_axis_tdata[$bits(bwrs_pkg::t_result)-1:0]);
                    if (got.burn_active !== want.burn_active) begin
                        $error("burn_active: expected %0d, got %0d",
                               want.burn_active, got.burn_active);
                        fail_count++;
                    end
                    if (got.burn_duty !== want.burn_duty) begin
                        $error("burn_duty: expected %0d, got %0d",
                               want.burn_duty, got.burn_duty);
                        fail_count++;
                    end
                    if (got.watchdog_kick !== want.watchdog_kick) begin
                        $error("watchdog_kick: expected %0d, got %0d",
                               want.watchdog_kick, got.watchdog_kick);
                        fail_count++;
                    end
                    if (got.done_res !== want.done_res) begin
                        $error("done_res: expected %0d, got %0d",
                               want.done_res, got.done_res);
                        fail_count++;
                    end
                    if (got.success !== want.success) begin
                        $error("success: expected %0d, got %0d",
                               want.success, got.success);
                        fail_count++;
                    end
                    if (m_axis_tdata[15:$bits(bwrs_pkg::t_result)] !== '0) begin
                        $error("tdata padding: expected 0, got %h",
                               m_axis_tdata[15:$bits(bwrs_pkg::t_result)]);
                        fail_count++;
                    end
                end
            end
            // one long hold-off so the block backs up into its input
            if (!pressure_done && results_seen >= 200) begin
                pressure_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                hold_left = $urandom_range(0, 4);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        cfg_first_s = bwrs_pkg::RST_FIRST_WINDOW;
        cfg_retry_s = bwrs_pkg::RST_RETRY_WINDOW;
        cfg_attempts = bwrs_pkg::RST_MAX_ATTEMPTS;
        cfg_pause = bwrs_pkg::RST_PAUSE_TICKS;
        cfg_duty_start = bwrs_pkg::RST_DUTY_START;
        cfg_duty_step = bwrs_pkg::RST_DUTY_STEP;
        seq_phase = bwrs_pkg::PH_IDLE;
        seq_attempt = '0;
        seq_ticks = '0;
        seq_window = '0;
        seq_duty = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: idle ticks, confirmations, restarts, both window choices
        push_item(KIND_TICK, 1'b0, 1'b0);
        push_item(KIND_TICK, 1'b1, 1'b1);
        push_item(KIND_START, 1'b0, 1'b1);
        push_item(KIND_TICK, 1'b0, 1'b0);
        push_item(KIND_TICK, 1'b1, 1'b0);
        push_item(KIND_TICK, 1'b0, 1'b1);
        push_item(KIND_TICK, 1'b0, 1'b1);
        push_item(KIND_START, 1'b1, 1'b0);
        push_item(KIND_TICK, 1'b1, 1'b0);
        push_item(KIND_START, 1'b0, 1'b0);
        push_item(KIND_TICK, 1'b0, 1'b0);
        push_item(KIND_START, 1'b1, 1'b1);
        push_item(KIND_START, 1'b1, 1'b0);
        push_item(KIND_TICK, 1'b0, 1'b0);
        push_item(KIND_TICK, 1'b1, 1'b1);
        push_item(KIND_TICK, 1'b1, 1'b0);
        push_item(KIND_START, 1'b0, 1'b0);
        push_item(KIND_TICK, 1'b1, 1'b0);
        push_item(KIND_TICK, 1'b0, 1'b0);
        push_item(KIND_TICK, 1'b1, 1'b1);
        drain();

        // defaults: long windows, several retries with pauses
        queue_sequences(350, 1200);
        drain();

        // zero pause, duty raise saturates at once
        load_settings(8'd1, 8'd2, 4'd3, 16'd0, 7'd0, 7'd100);
        queue_sequences(250, 700);
        drain();

        // zero window and attempt registers, duty start above 100
        load_settings(8'd0, 8'd0, 4'd0, 16'd7, 7'd127, 7'd127);
        queue_sequences(250, 250);
        drain();

        // most attempts, one-tick pause, no duty raise
        load_settings(8'd1, 8'd1, 4'd15, 16'd1, 7'd100, 7'd0);
        queue_sequences(250, 400);
        drain();

        // widest windows and pause
        load_settings(8'd255, 8'd255, 4'd2, 16'hFFFF, 7'd64, 7'd33);
        queue_sequences(100, 60);
        drain();

        calm = 1'b1;
        load_settings(8'd2, 8'd1, 4'd4, 16'd3, 7'd50, 7'd25);
        queue_sequences(250, 500);
        drain();

        repeat (6) @(posedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
